[hw/rtl/pft_pkg.sv]
// shared types and constants for the plane-from-three-points unit
`timescale 1ns / 1ps

package pft_pkg;

	// fixed port widths of the unit
	localparam int unsigned COORD_PORT_W  = 12;
	localparam int unsigned NORMAL_PORT_W = 16;
	localparam int unsigned OFFSET_PORT_W = 28;
	localparam int unsigned MAG_PORT_W    = 26;

	// control travelling alongside each pipeline transaction
	typedef struct packed {
		logic valid;
		logic degen;
	} pft_ctl_t;

endpackage

[hw/rtl/plane_from_three_points_unit.sv]
// plane through three points: cross product, square root, unit normal, offset
`timescale 1ns / 1ps
// pipeline: front stages, square root chain, divider chain, then the final stages
// throughput: one transaction per cycle, busy is never raised
// the square root chain gives one root bit per cell, the divider chain one quotient bit
// per cell for all three normal components, so chain length sets the latency
// reset clears only the pipeline control (valid and degen bits) and done; payload registers are not reset
// the receiver cannot stall: each result shows for one cycle with done high

module plane_from_three_points_unit import pft_pkg::*; #(
	parameter int unsigned COORD_BITS       = 12,
	parameter int unsigned NORMAL_FRAC_BITS = 15
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic signed [COORD_PORT_W-1:0]  first_x,
	input  logic signed [COORD_PORT_W-1:0]  first_y,
	input  logic signed [COORD_PORT_W-1:0]  first_z,
	input  logic signed [COORD_PORT_W-1:0]  second_x,
	input  logic signed [COORD_PORT_W-1:0]  second_y,
	input  logic signed [COORD_PORT_W-1:0]  second_z,
	input  logic signed [COORD_PORT_W-1:0]  third_x,
	input  logic signed [COORD_PORT_W-1:0]  third_y,
	input  logic signed [COORD_PORT_W-1:0]  third_z,
	output logic                            done,
	output logic signed [NORMAL_PORT_W-1:0] normal_x,
	output logic signed [NORMAL_PORT_W-1:0] normal_y,
	output logic signed [NORMAL_PORT_W-1:0] normal_z,
	output logic signed [OFFSET_PORT_W-1:0] plane_offset,
	output logic        [MAG_PORT_W-1:0]    cross_magnitude,
	output logic                            degenerate
);

	localparam int unsigned CB  = COORD_BITS;
	localparam int unsigned EW  = CB + 1;           // edge vector width
	localparam int unsigned PW  = 2 * EW;           // partial product width
	localparam int unsigned CW  = PW + 1;           // cross component width
	localparam int unsigned MW  = CW;               // magnitude width
	localparam int unsigned SQW = 2 * MW;           // squared length width
	localparam int unsigned QW  = NORMAL_FRAC_BITS + 1;
	localparam int unsigned NW  = NORMAL_FRAC_BITS + 1;
	localparam int unsigned DW  = NW + CB;          // normal times coordinate
	localparam int unsigned OW  = DW + 3;           // offset before truncation
	localparam int unsigned SIDE1_W = 4 + 3 * MW + 3 * CB;
	localparam int unsigned SIDE2_W = 4 + 3 * CB;
	localparam int unsigned LAT = 5 + MW + QW + 3;

	// no backpressure anywhere, a new transaction can enter every cycle
	logic accept;
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// stage 1: sign extension of the used coordinate bits and edge vectors
	logic signed [CB-1:0] p0x, p0y, p0z, p1x, p1y, p1z, p2x, p2y, p2z;
	assign p0x = first_x[CB-1:0];
	assign p0y = first_y[CB-1:0];
	assign p0z = first_z[CB-1:0];
	assign p1x = second_x[CB-1:0];
	assign p1y = second_y[CB-1:0];
	assign p1z = second_z[CB-1:0];
	assign p2x = third_x[CB-1:0];
	assign p2y = third_y[CB-1:0];
	assign p2z = third_z[CB-1:0];

	logic                       vld_s1;
	logic signed [EW-1:0]       e1x_s1, e1y_s1, e1z_s1, e2x_s1, e2y_s1, e2z_s1;
	logic signed [2:0][CB-1:0]  p0_s1;

	always_ff @(posedge clk) begin
		e1x_s1 <= EW'(p1x) - EW'(p0x);
		e1y_s1 <= EW'(p1y) - EW'(p0y);
		e1z_s1 <= EW'(p1z) - EW'(p0z);
		e2x_s1 <= EW'(p2x) - EW'(p0x);
		e2y_s1 <= EW'(p2y) - EW'(p0y);
		e2z_s1 <= EW'(p2z) - EW'(p0z);
		p0_s1  <= {p0z, p0y, p0x};
	end

	// stage 2: the six partial products of the cross product
	logic                       vld_s2;
	logic signed [PW-1:0]       pa_s2, pb_s2, pc_s2, pd_s2, pe_s2, pf_s2;
	logic signed [2:0][CB-1:0]  p0_s2;

	always_ff @(posedge clk) begin
		pa_s2 <= e1y_s1 * e2z_s1;
		pb_s2 <= e1z_s1 * e2y_s1;
		pc_s2 <= e1z_s1 * e2x_s1;
		pd_s2 <= e1x_s1 * e2z_s1;
		pe_s2 <= e1x_s1 * e2y_s1;
		pf_s2 <= e1y_s1 * e2x_s1;
		p0_s2 <= p0_s1;
	end

	// stage 3: cross product components
	logic                       vld_s3;
	logic signed [CW-1:0]       cx_s3, cy_s3, cz_s3;
	logic signed [2:0][CB-1:0]  p0_s3;

	always_ff @(posedge clk) begin
		cx_s3 <= CW'(pa_s2) - CW'(pb_s2);
		cy_s3 <= CW'(pc_s2) - CW'(pd_s2);
		cz_s3 <= CW'(pe_s2) - CW'(pf_s2);
		p0_s3 <= p0_s2;
	end

	// stage 4: squares, magnitudes and signs of the components
	logic                       vld_s4;
	logic signed [SQW-1:0]      sqx_s4, sqy_s4, sqz_s4;
	logic [2:0][MW-1:0]         abs_s4;
	logic [2:0]                 sgn_s4;
	logic                       deg_s4;
	logic signed [2:0][CB-1:0]  p0_s4;

	always_ff @(posedge clk) begin
		sqx_s4 <= cx_s3 * cx_s3;
		sqy_s4 <= cy_s3 * cy_s3;
		sqz_s4 <= cz_s3 * cz_s3;
		abs_s4 <= {cz_s3[CW-1] ? MW'(-cz_s3) : MW'(cz_s3),
		           cy_s3[CW-1] ? MW'(-cy_s3) : MW'(cy_s3),
		           cx_s3[CW-1] ? MW'(-cx_s3) : MW'(cx_s3)};
		sgn_s4 <= {cz_s3[CW-1], cy_s3[CW-1], cx_s3[CW-1]};
		deg_s4 <= (cx_s3 == '0) && (cy_s3 == '0) && (cz_s3 == '0);
		p0_s4  <= p0_s3;
	end

	// stage 5: squared length
	logic                       vld_s5;
	logic [SQW-1:0]             sq_s5;
	logic [SIDE1_W-1:0]         side1_s5;

	always_ff @(posedge clk) begin
		sq_s5    <= SQW'(sqx_s4) + SQW'(sqy_s4) + SQW'(sqz_s4);
		side1_s5 <= {deg_s4, sgn_s4, abs_s4, p0_s4};
	end

	// valid bits of the front stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// square root chain, two radicand bits per cell
	pft_ctl_t               sq_ctl  [MW+1];
	logic [SQW-1:0]         sq_rad  [MW+1];
	logic [MW+1:0]          sq_rem  [MW+1];
	logic [MW-1:0]          sq_root [MW+1];
	logic [SIDE1_W-1:0]     sq_side [MW+1];

	assign sq_ctl[0]  = '{valid: vld_s5, degen: side1_s5[SIDE1_W-1]};
	assign sq_rad[0]  = sq_s5;
	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;
	assign sq_side[0] = side1_s5;

	for (genvar k = 0; k < MW; k++) begin : g_sqrt
		pft_sqrt_cell #(.MW(MW), .SIDE_W(SIDE1_W)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl_in   (sq_ctl[k]),
			.rad_in   (sq_rad[k]),
			.rem_in   (sq_rem[k]),
			.root_in  (sq_root[k]),
			.side_in  (sq_side[k]),
			.ctl_out  (sq_ctl[k+1]),
			.rad_out  (sq_rad[k+1]),
			.rem_out  (sq_rem[k+1]),
			.root_out (sq_root[k+1]),
			.side_out (sq_side[k+1])
		);
	end

	// unpack the side bundle at the end of the root chain
	logic [SIDE1_W-1:0]     side1_end;
	logic [2:0][MW-1:0]     abs_end;
	logic [SIDE2_W-1:0]     side2_start;

	assign side1_end   = sq_side[MW];
	assign abs_end     = side1_end[3*CB +: 3*MW];
	assign side2_start = {side1_end[SIDE1_W-1 -: 4], side1_end[3*CB-1:0]};

	// divider chain: |c| * 2^frac / magnitude, one bit per cell, three lanes
	pft_ctl_t               dv_ctl  [QW+1];
	logic [MW-1:0]          dv_mag  [QW+1];
	logic [2:0][MW:0]       dv_rem  [QW+1];
	logic [2:0][QW-1:0]     dv_quo  [QW+1];
	logic [SIDE2_W-1:0]     dv_side [QW+1];

	assign dv_ctl[0]  = sq_ctl[MW];
	assign dv_mag[0]  = sq_root[MW];
	assign dv_rem[0]  = {{1'b0, abs_end[2]}, {1'b0, abs_end[1]}, {1'b0, abs_end[0]}};
	assign dv_quo[0]  = '0;
	assign dv_side[0] = side2_start;

	for (genvar k = 0; k < QW; k++) begin : g_div
		pft_div_cell #(.MW(MW), .QW(QW), .SIDE_W(SIDE2_W)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl_in   (dv_ctl[k]),
			.mag_in   (dv_mag[k]),
			.rem_in   (dv_rem[k]),
			.quo_in   (dv_quo[k]),
			.side_in  (dv_side[k]),
			.ctl_out  (dv_ctl[k+1]),
			.mag_out  (dv_mag[k+1]),
			.rem_out  (dv_rem[k+1]),
			.quo_out  (dv_quo[k+1]),
			.side_out (dv_side[k+1])
		);
	end

	logic [SIDE2_W-1:0]         side2_end;
	logic [2:0]                 sgn_end;
	logic signed [2:0][CB-1:0]  p0_end;
	logic [2:0][QW-1:0]         quo_end;
	pft_ctl_t                   ctl_end;

	assign side2_end = dv_side[QW];
	assign sgn_end   = side2_end[3*CB +: 3];
	assign p0_end    = side2_end[3*CB-1:0];
	assign quo_end   = dv_quo[QW];
	assign ctl_end   = dv_ctl[QW];

	// final 1: sign and saturation of the unit normal, zero plane when degenerate
	localparam logic [QW-1:0] ONE_Q = QW'(1) << NORMAL_FRAC_BITS;

	logic signed [2:0][NW-1:0] n_nx;
	always_comb begin
		for (int l = 0; l < 3; l++) begin
			if (side2_end[SIDE2_W-1]) begin
				n_nx[l] = '0;
			end else if (sgn_end[l]) begin
				n_nx[l] = NW'(~quo_end[l] + QW'(1));
			end else if (quo_end[l] == ONE_Q) begin
				n_nx[l] = NW'(ONE_Q - QW'(1));
			end else begin
				n_nx[l] = NW'(quo_end[l]);
			end
		end
	end

	pft_ctl_t                   ctl_f1;
	logic signed [2:0][NW-1:0]  n_f1;
	logic signed [2:0][CB-1:0]  p0_f1;
	logic [MW-1:0]              mag_f1;

	always_ff @(posedge clk) begin
		n_f1   <= n_nx;
		p0_f1  <= p0_end;
		mag_f1 <= dv_mag[QW];
	end

	// final 2: normal times first point, per axis
	pft_ctl_t                   ctl_f2;
	logic signed [DW-1:0]       dx_f2, dy_f2, dz_f2;
	logic signed [2:0][NW-1:0]  n_f2;
	logic [MW-1:0]              mag_f2;

	always_ff @(posedge clk) begin
		dx_f2  <= DW'($signed(n_f1[0])) * DW'($signed(p0_f1[0]));
		dy_f2  <= DW'($signed(n_f1[1])) * DW'($signed(p0_f1[1]));
		dz_f2  <= DW'($signed(n_f1[2])) * DW'($signed(p0_f1[2]));
		n_f2   <= n_f1;
		mag_f2 <= mag_f1;
	end

	// final 3: offset is minus the dot product, then the output registers
	logic signed [OW-1:0] off_full;
	logic signed [63:0]   off_wide;
	logic [63:0]          mag_wide;

	always_comb begin
		off_full = OW'(0) - (OW'(dx_f2) + OW'(dy_f2) + OW'(dz_f2));
		off_wide = 64'(off_full);
		mag_wide = 64'(mag_f2);
	end

	always_ff @(posedge clk) begin
		normal_x        <= NORMAL_PORT_W'($signed(n_f2[0]));
		normal_y        <= NORMAL_PORT_W'($signed(n_f2[1]));
		normal_z        <= NORMAL_PORT_W'($signed(n_f2[2]));
		plane_offset    <= off_wide[OFFSET_PORT_W-1:0];
		cross_magnitude <= mag_wide[MAG_PORT_W-1:0];
		degenerate      <= ctl_f2.degen;
	end

	// control of the final stages and done, valid and degen are both reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_f1 <= '0;
			ctl_f2 <= '0;
			done   <= 1'b0;
		end else begin
			ctl_f1 <= ctl_end;
			ctl_f2 <= ctl_f1;
			done   <= ctl_f2.valid;
		end
	end

	// every accepted transaction comes out with done high at the end of the pipeline
	assert property (@(posedge clk) disable iff (!arst_n) accept |-> ##LAT done)
		else $error("result strobe missing after fixed latency");

	// a degenerate result carries a zero plane
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && degenerate) |-> (normal_x == '0 && normal_y == '0 &&
		                          normal_z == '0 && plane_offset == '0 &&
		                          cross_magnitude == '0))
		else $error("degenerate result with nonzero plane");

	// a proper triangle always has a nonzero magnitude
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && !degenerate) |-> (cross_magnitude != '0))
		else $error("zero magnitude on a nondegenerate result");

	// a valid proper triangle never leaves the divider chain with a zero divisor
	assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_end.valid && !ctl_end.degen) |-> (dv_mag[QW] != '0))
		else $error("divider chain reached end with zero divisor");

endmodule

[hw/rtl/pft_sqrt_cell.sv]
// one cell of the square root chain: one root bit per cell
`timescale 1ns / 1ps

module pft_sqrt_cell import pft_pkg::*; #(
	parameter int unsigned MW     = 27,
	parameter int unsigned SIDE_W = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  pft_ctl_t            ctl_in,
	input  logic [2*MW-1:0]     rad_in,
	input  logic [MW+1:0]       rem_in,
	input  logic [MW-1:0]       root_in,
	input  logic [SIDE_W-1:0]   side_in,
	output pft_ctl_t            ctl_out,
	output logic [2*MW-1:0]     rad_out,
	output logic [MW+1:0]       rem_out,
	output logic [MW-1:0]       root_out,
	output logic [SIDE_W-1:0]   side_out
);

	logic [MW+3:0] rem_sh;
	logic [MW+3:0] trial;
	logic          take;
	logic [MW+3:0] rem_nx;

	always_comb begin
		rem_sh = {rem_in, rad_in[2*MW-1 -: 2]};
		trial  = {2'b00, root_in, 2'b01};
		take   = (rem_sh >= trial);
		rem_nx = take ? (rem_sh - trial) : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_out <= '0;
		end else begin
			ctl_out <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		rad_out  <= {rad_in[2*MW-3:0], 2'b00};
		rem_out  <= rem_nx[MW+1:0];
		root_out <= {root_in[MW-2:0], take};
		side_out <= side_in;
	end

endmodule

[hw/rtl/pft_div_cell.sv]
// one cell of the divider chain: one quotient bit for each of three lanes
`timescale 1ns / 1ps

module pft_div_cell import pft_pkg::*; #(
	parameter int unsigned MW     = 27,
	parameter int unsigned QW     = 16,
	parameter int unsigned SIDE_W = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  pft_ctl_t            ctl_in,
	input  logic [MW-1:0]       mag_in,
	input  logic [2:0][MW:0]    rem_in,
	input  logic [2:0][QW-1:0]  quo_in,
	input  logic [SIDE_W-1:0]   side_in,
	output pft_ctl_t            ctl_out,
	output logic [MW-1:0]       mag_out,
	output logic [2:0][MW:0]    rem_out,
	output logic [2:0][QW-1:0]  quo_out,
	output logic [SIDE_W-1:0]   side_out
);

	logic [2:0]       bit_q;
	logic [2:0][MW:0] rem_left;

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			bit_q[l]    = (rem_in[l] >= {1'b0, mag_in});
			rem_left[l] = bit_q[l] ? (rem_in[l] - {1'b0, mag_in}) : rem_in[l];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_out <= '0;
		end else begin
			ctl_out <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		mag_out  <= mag_in;
		side_out <= side_in;
		for (int l = 0; l < 3; l++) begin
			rem_out[l] <= {rem_left[l][MW-1:0], 1'b0};
			quo_out[l] <= {quo_in[l][QW-2:0], bit_q[l]};
		end
	end

endmodule

[verif/tb_plane_from_three_points_unit.sv]
// testbench for the plane-from-three-points unit: directed and random triangles
`timescale 1ns / 1ps

module tb_plane_from_three_points_unit import pft_pkg::*;;

	localparam int unsigned LATENCY     = 51;
	localparam int unsigned CYCLE_LIMIT = 200000;

	// one expected plane per accepted triangle
	typedef struct {
		logic signed [NORMAL_PORT_W-1:0] nx;
		logic signed [NORMAL_PORT_W-1:0] ny;
		logic signed [NORMAL_PORT_W-1:0] nz;
		logic signed [OFFSET_PORT_W-1:0] offset;
		logic        [MAG_PORT_W-1:0]    mag;
		logic                            degen;
	} plane_t;

	typedef logic signed [COORD_PORT_W-1:0] coord_t;

	logic   clk;
	logic   arst_n;
	logic   start;
	logic   busy;
	coord_t first_x, first_y, first_z;
	coord_t second_x, second_y, second_z;
	coord_t third_x, third_y, third_z;
	logic   done;
	logic signed [NORMAL_PORT_W-1:0] normal_x, normal_y, normal_z;
	logic signed [OFFSET_PORT_W-1:0] plane_offset;
	logic        [MAG_PORT_W-1:0]    cross_magnitude;
	logic                            degenerate;

	plane_t      expected_planes[$];
	int unsigned error_count;
	int unsigned cycle_count;
	bit          allow_gaps;

	plane_from_three_points_unit u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.first_x(first_x), .first_y(first_y), .first_z(first_z),
		.second_x(second_x), .second_y(second_y), .second_z(second_z),
		.third_x(third_x), .third_y(third_y), .third_z(third_z),
		.done(done), .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
		.plane_offset(plane_offset), .cross_magnitude(cross_magnitude),
		.degenerate(degenerate)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// bit-serial floor square root of the squared cross length
	function automatic longint unsigned floor_sqrt(longint unsigned v);
		longint unsigned root;
		longint unsigned bitpos;
		root   = 0;
		bitpos = 64'd1 << 62;
		while (bitpos > v)
			bitpos >>= 2;
		while (bitpos != 0) begin
			if (v >= root + bitpos) begin
				v    = v - (root + bitpos);
				root = (root >> 1) + bitpos;
			end else begin
				root >>= 1;
			end
			bitpos >>= 2;
		end
		return root;
	endfunction

	// one normal component in Q1.15: truncate toward zero, clamp +1 only
	function automatic longint unit_part(longint c, longint unsigned mag);
		longint unsigned q;
		q = ((c < 0 ? -c : c) << 15) / mag;
		if (c < 0)
			return -longint'(q);
		if (q >= 64'd32768)
			q = 64'd32767;
		return longint'(q);
	endfunction

	function automatic plane_t plane_of(coord_t p[9]);
		longint e1[3], e2[3], c[3], n[3];
		longint unsigned mag;
		longint dot;
		plane_t r;
		for (int i = 0; i < 3; i++) begin
			e1[i] = longint'(p[3+i]) - longint'(p[i]);
			e2[i] = longint'(p[6+i]) - longint'(p[i]);
		end
		c[0] = e1[1]*e2[2] - e1[2]*e2[1];
		c[1] = e1[2]*e2[0] - e1[0]*e2[2];
		c[2] = e1[0]*e2[1] - e1[1]*e2[0];
		r = '{default: '0};
		if (c[0] == 0 && c[1] == 0 && c[2] == 0) begin
			r.degen = 1'b1;
			return r;
		end
		mag = floor_sqrt(c[0]*c[0] + c[1]*c[1] + c[2]*c[2]);
		for (int i = 0; i < 3; i++)
			n[i] = unit_part(c[i], mag);
		dot      = n[0]*p[0] + n[1]*p[1] + n[2]*p[2];
		r.nx     = n[0][15:0];
		r.ny     = n[1][15:0];
		r.nz     = n[2][15:0];
		r.offset = OFFSET_PORT_W'(-dot);
		r.mag    = mag[25:0];
		return r;
	endfunction

	// sends one triangle, with a random idle burst ahead of it while gaps are on
	task automatic send_triangle(coord_t p[9]);
		if (allow_gaps && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		start    <= 1'b1;
		first_x  <= p[0]; first_y  <= p[1]; first_z  <= p[2];
		second_x <= p[3]; second_y <= p[4]; second_z <= p[5];
		third_x  <= p[6]; third_y  <= p[7]; third_z  <= p[8];
		@(posedge clk);
		while (busy)
			@(posedge clk);
		// transaction accepted at this edge
		expected_planes.push_back(plane_of(p));
	endtask

	task automatic idle_start();
		start <= 1'b0;
	endtask

	function automatic coord_t rand_coord();
		return coord_t'($urandom);
	endfunction

	// extremes, collinear and coincident points, axis-aligned planes
	task automatic test_directed();
		coord_t p[9];
		coord_t mx, mn;
		mx = 12'sd2047;
		mn = coord_t'(-2048);
		p = '{default: 0};
		send_triangle(p);  // all coincident
		p = '{1, 2, 3, 2, 4, 6, 3, 6, 9};
		send_triangle(p);  // collinear
		p = '{0, 0, 0, 1, 0, 0, 0, 1, 0};
		send_triangle(p);  // normal +z, saturates to 32767
		p = '{0, 0, 0, 0, 1, 0, 1, 0, 0};
		send_triangle(p);  // normal -z, stays -32768
		p = '{5, 5, 5, 5, 6, 5, 5, 5, 6};
		send_triangle(p);  // +x with offset
		p = '{mn, mn, mn, mx, mn, mn, mn, mx, mn};
		send_triangle(p);  // largest xy triangle
		p = '{mn, mn, mn, mx, mn, mn, mn, mx, mx};
		send_triangle(p);
		p = '{mx, mx, mx, mn, mx, mn, mx, mn, mn};
		send_triangle(p);
		p = '{mn, mx, mn, mx, mn, mx, mn, mn, mx};
		send_triangle(p);
		p = '{mx, mn, mx, mn, mx, mn, mn, mn, mx};
		send_triangle(p);
		p = '{mx, mx, mx, mx, mx, mx, mn, mn, mn};
		send_triangle(p);  // two coincident points
		p = '{-1, -1, -1, 0, 0, 0, 1, 1, 1};
		send_triangle(p);  // collinear through origin
		p = '{mx, 0, 0, 0, mx, 0, 0, 0, mx};
		send_triangle(p);  // diagonal normal
		p = '{-7, 3, 11, 100, -50, 20, -30, 90, -60};
		send_triangle(p);
	endtask

	// random triangles: mostly full range, some small, some collinear
	task automatic test_random(int unsigned count);
		coord_t p[9];
		int unsigned kind;
		int k;
		for (int unsigned n = 0; n < count; n++) begin
			kind = $urandom_range(0, 9);
			for (int i = 0; i < 9; i++)
				p[i] = (kind < 6) ? rand_coord() : coord_t'($urandom_range(0, 16) - 8);
			if (kind == 9) begin
				// collinear: third point on the line through the first two
				k = $urandom_range(0, 4) - 2;
				for (int i = 0; i < 3; i++)
					p[6+i] = coord_t'(p[i] + k * (p[3+i] - p[i]));
			end
			send_triangle(p);
		end
	endtask

	// checks every result against the oldest expected plane
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_planes.size() == 0) begin
				$error("result with no transaction pending");
				error_count++;
			end else begin
				plane_t e;
				e = expected_planes.pop_front();
				if (normal_x !== e.nx) begin
					$error("normal_x exp %0d got %0d", e.nx, normal_x); error_count++;
				end
				if (normal_y !== e.ny) begin
					$error("normal_y exp %0d got %0d", e.ny, normal_y); error_count++;
				end
				if (normal_z !== e.nz) begin
					$error("normal_z exp %0d got %0d", e.nz, normal_z); error_count++;
				end
				if (plane_offset !== e.offset) begin
					$error("plane_offset exp %0d got %0d", e.offset, plane_offset);
					error_count++;
				end
				if (cross_magnitude !== e.mag) begin
					$error("cross_magnitude exp %0d got %0d", e.mag, cross_magnitude);
					error_count++;
				end
				if (degenerate !== e.degen) begin
					$error("degenerate exp %0d got %0d", e.degen, degenerate);
					error_count++;
				end
			end
		end
	end

	// watchdog on total run length
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("plane_from_three_points_unit: mismatch");
			$finish;
		end
	end

	initial begin
		error_count = 0;
		cycle_count = 0;
		allow_gaps  = 1'b1;
		arst_n   = 1'b0;
		start    = 1'b0;
		first_x  = '0; first_y  = '0; first_z  = '0;
		second_x = '0; second_y = '0; second_z = '0;
		third_x  = '0; third_y  = '0; third_z  = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(1200);
		// closing stretch back to back
		allow_gaps = 1'b0;
		test_random(300);
		idle_start();
		while (expected_planes.size() != 0)
			@(posedge clk);
		repeat (LATENCY) @(posedge clk);
		if (error_count == 0)
			$display("plane_from_three_points_unit: match");
		else
			$display("plane_from_three_points_unit: mismatch");
		$finish;
	end

endmodule

[sim.f]
hw/rtl/pft_pkg.sv
hw/rtl/pft_sqrt_cell.sv
hw/rtl/pft_div_cell.sv
hw/rtl/plane_from_three_points_unit.sv
verif/tb_plane_from_three_points_unit.sv
